// ===== hw/rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types, widths and helpers for the 3d spring force core
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int POS_W  = 32;          // position field width
  localparam int MAG_W  = 33;          // magnitude of a position difference
  localparam int SQ_W   = 65;          // one squared difference
  localparam int SUM_W  = 66;          // sum of three squares
  localparam int ROOT_W = 34;          // distance
  localparam int STR_W  = 34;          // stretch magnitude
  localparam int PROD_W = 66;          // stiffness times stretch
  localparam int NUM_W  = 99;          // product times one difference
  localparam int Q_W    = 33;          // quotient bits kept below overflow
  localparam int BLD_W  = 17;          // stress blend width
  localparam int BX_W   = 19;          // blend operand before divide by five

  // divide by five through a reciprocal, exact below 2^19
  localparam logic [BX_W-1:0] BLEND_MUL = 19'd419431;
  localparam int              BLEND_SH  = 21;
  localparam logic [BLD_W-1:0] BLEND_ONE = 17'h10000;

  localparam logic [31:0] STIFF_RESET = 32'h0001_0000;
  localparam logic [30:0] REST_RESET  = 31'h0001_0000;

  // register indexes on the config port
  localparam logic REG_STIFFNESS = 1'b0;
  localparam logic REG_REST_LEN  = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] end_a_x;
    logic signed [POS_W-1:0] end_a_y;
    logic signed [POS_W-1:0] end_a_z;
    logic signed [POS_W-1:0] end_b_x;
    logic signed [POS_W-1:0] end_b_y;
    logic signed [POS_W-1:0] end_b_z;
    logic                    frozen;
  } req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] force_x;
    logic signed [POS_W-1:0] force_y;
    logic signed [POS_W-1:0] force_z;
    logic                    apply;
    logic [BLD_W-1:0]        stress_blend;
  } rsp_t;

  // signed saturation of a quotient magnitude
  function automatic logic [POS_W-1:0] sat_force(input logic neg,
                                                 input logic [Q_W-1:0] q,
                                                 input logic ovf);
    logic [POS_W-1:0] res;
    if (!ovf && q == '0) begin
      res = '0;
    end else if (neg) begin
      if (ovf || q > Q_W'(33'h0_8000_0000)) res = 32'h8000_0000;
      else res = POS_W'(Q_W'(0) - q);
    end else begin
      if (ovf || q > Q_W'(33'h0_7FFF_FFFF)) res = 32'h7FFF_FFFF;
      else res = POS_W'(q);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/sfd_sqrt.sv =====
// ----------------------------------------------------------------------------
// sfd_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module sfd_sqrt (
  input  logic                       clk,
  input  logic [sfd_pkg::SUM_W-1:0]  sq_sum,
  output logic [sfd_pkg::ROOT_W-1:0] root
);

  localparam int SW = sfd_pkg::SUM_W;
  localparam int RW = sfd_pkg::ROOT_W;
  localparam int CW = 2 * RW + 1;

  logic [SW-1:0] s_q  [RW+1];
  logic [RW-1:0] r_q  [RW+1];
  logic [SW-1:0] r2_q [RW+1];

  assign s_q[0]  = sq_sum;
  assign r_q[0]  = '0;
  assign r2_q[0] = '0;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int B = RW - 1 - j;
    logic [CW-1:0] cand;
    logic          take;
    // (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b)
    assign cand = CW'(r2_q[j]) + (CW'(r_q[j]) << (B + 1)) + (CW'(1) << (2 * B));
    assign take = cand <= CW'(s_q[j]);
    always_ff @(posedge clk) begin
      s_q[j+1]  <= s_q[j];
      r_q[j+1]  <= take ? (r_q[j] | (RW'(1) << B)) : r_q[j];
      r2_q[j+1] <= take ? cand[SW-1:0] : r2_q[j];
    end
  end

  assign root = r_q[RW];

endmodule

// ===== hw/rtl/sfd_div.sv =====
// ----------------------------------------------------------------------------
// sfd_div
// pipelined restoring divider, one quotient bit per stage, overflow flag
// ----------------------------------------------------------------------------
module sfd_div #(
  parameter int DIV_W = 50
) (
  input  logic                      clk,
  input  logic [sfd_pkg::NUM_W-1:0] num,
  input  logic [DIV_W-1:0]          den,
  output logic [sfd_pkg::Q_W-1:0]   quo,
  output logic                      ovf
);

  localparam int NW = sfd_pkg::NUM_W;
  localparam int QW = sfd_pkg::Q_W;
  localparam int CW = ((NW > DIV_W + QW) ? NW : DIV_W + QW) + 1;

  logic [NW-1:0]    rem_q [QW+1];
  logic [DIV_W-1:0] den_q [QW+1];
  logic [QW-1:0]    quo_q [QW+1];
  logic             ovf_q [QW+1];

  assign rem_q[0] = num;
  assign den_q[0] = den;
  assign quo_q[0] = '0;
  // quotient at or above 2^QW
  assign ovf_q[0] = CW'(num) >= (CW'(den) << QW);

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic [CW-1:0] sh;
    logic          take;
    assign sh   = CW'(den_q[j]) << K;
    assign take = CW'(rem_q[j]) >= sh;
    always_ff @(posedge clk) begin
      rem_q[j+1] <= take ? (rem_q[j] - sh[NW-1:0]) : rem_q[j];
      den_q[j+1] <= den_q[j];
      quo_q[j+1] <= take ? (quo_q[j] | (QW'(1) << K)) : quo_q[j];
      ovf_q[j+1] <= ovf_q[j];
    end
  end

  assign quo = quo_q[QW];
  assign ovf = ovf_q[QW];

endmodule

// ===== hw/rtl/spring_force_3d_core.sv =====
// ----------------------------------------------------------------------------
// spring_force_3d_core
// hooke spring force on end a of a 3d spring, with stress blend factor
// ----------------------------------------------------------------------------
// pipeline from an accepted request to its done strobe:
//   (3 setup stages, 34 square root stages, 4 multiply stages,
//    33 divider stages, 1 output stage)
// throughput: one request per cycle, busy is never raised
// reset: rst clears the valid pipeline and loads stiffness and rest length
//   with 1.0; results leave on done for one cycle and cannot be stalled
// ----------------------------------------------------------------------------
module spring_force_3d_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  // request channel
  input  logic          start,
  output logic          busy,
  input  sfd_pkg::req_t req,
  // result channel
  output logic          done,
  output sfd_pkg::rsp_t result,
  // config port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int MW    = sfd_pkg::MAG_W;
  localparam int RW    = sfd_pkg::ROOT_W;
  localparam int PW    = sfd_pkg::PROD_W;
  localparam int QW    = sfd_pkg::Q_W;
  localparam int DIV_W = RW + FRAC_BITS;
  localparam int LAT   = 3 + RW + 4 + QW + 1;
  // saturation threshold for the blend: |force| >= 5.0
  localparam logic [PW-1:0] THR = PW'(5) << (2 * FRAC_BITS);

  typedef struct packed {
    logic                   frozen;
    logic [2:0]             dneg;
    logic [2:0][MW-1:0]     u;
  } sq_side_t;

  typedef struct packed {
    logic                     frozen;
    logic [2:0]               neg;
    logic                     zero;
    logic [sfd_pkg::BLD_W-1:0] blend;
  } dv_side_t;

  // --------------------------------------------------------------------------
  // config registers
  // --------------------------------------------------------------------------
  logic [31:0] stiffness;
  logic [30:0] rest_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness   <= sfd_pkg::STIFF_RESET;
      rest_length <= sfd_pkg::REST_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        sfd_pkg::REG_STIFFNESS: stiffness   <= pwdata;
        sfd_pkg::REG_REST_LEN:  rest_length <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sfd_pkg::REG_STIFFNESS: prdata = stiffness;
      sfd_pkg::REG_REST_LEN:  prdata = {1'b0, rest_length};
      default:                prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  // fully pipelined, a request is taken every cycle
  assign busy   = 1'b0;

  // --------------------------------------------------------------------------
  // stage 1: differences b - a and their magnitudes
  // --------------------------------------------------------------------------
  logic                  v1;
  sq_side_t              s1;
  logic [2:0][MW-1:0]    d_c;

  always_comb begin
    d_c[0] = {req.end_b_x[31], req.end_b_x} - {req.end_a_x[31], req.end_a_x};
    d_c[1] = {req.end_b_y[31], req.end_b_y} - {req.end_a_y[31], req.end_a_y};
    d_c[2] = {req.end_b_z[31], req.end_b_z} - {req.end_a_z[31], req.end_a_z};
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1.frozen <= req.frozen;
    for (int i = 0; i < 3; i++) begin
      s1.dneg[i] <= d_c[i][MW-1];
      s1.u[i]    <= d_c[i][MW-1] ? (MW'(0) - d_c[i]) : d_c[i];
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: squares, stage 3: sum of squares
  // --------------------------------------------------------------------------
  logic                           v2, v3;
  sq_side_t                       s2;
  logic [2:0][sfd_pkg::SQ_W-1:0]  sq2;
  logic [2:0][2*MW-1:0]           sq_full;
  logic [sfd_pkg::SUM_W-1:0]      sum3;

  always_comb begin
    for (int i = 0; i < 3; i++) sq_full[i] = s1.u[i] * s1.u[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= v1;
      v3 <= v2;
    end
  end

  sq_side_t sq_dl [RW+1];
  logic     sq_v  [RW+1];

  always_ff @(posedge clk) begin
    s2 <= s1;
    for (int i = 0; i < 3; i++) sq2[i] <= sq_full[i][sfd_pkg::SQ_W-1:0];
    sum3 <= sfd_pkg::SUM_W'(sq2[0]) + sfd_pkg::SUM_W'(sq2[1]) + sfd_pkg::SUM_W'(sq2[2]);
    sq_dl[0] <= s2;
  end

  // --------------------------------------------------------------------------
  // distance: square root pipeline with side data delayed alongside
  // --------------------------------------------------------------------------
  logic [RW-1:0] root;

  sfd_sqrt u_sqrt (
    .clk    (clk),
    .sq_sum (sum3),
    .root   (root)
  );

  assign sq_v[0] = v3;

  for (genvar k = 0; k < RW; k++) begin : g_sq_dly
    always_ff @(posedge clk) begin
      sq_dl[k+1] <= sq_dl[k];
      if (rst) sq_v[k+1] <= 1'b0;
      else     sq_v[k+1] <= sq_v[k];
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: stretch = distance - rest length
  // --------------------------------------------------------------------------
  logic                v4, v5, v6, v7;
  sq_side_t            s4, s5, s6;
  logic [RW-1:0]       root4, root5, root6;
  logic                zero4, zero5, zero6;
  logic                sneg4, sneg5, sneg6;
  logic [sfd_pkg::STR_W-1:0] smag4;
  logic [RW:0]         sdiff_c;

  assign sdiff_c = {1'b0, root} - (RW + 1)'(rest_length);

  always_ff @(posedge clk) begin
    s4    <= sq_dl[RW];
    root4 <= root;
    zero4 <= root == '0;
    sneg4 <= sdiff_c[RW];
    smag4 <= sfd_pkg::STR_W'(sdiff_c[RW] ? ((RW + 1)'(0) - sdiff_c) : sdiff_c);
  end

  // --------------------------------------------------------------------------
  // stage 5: stiffness times stretch
  // --------------------------------------------------------------------------
  logic [PW-1:0] prod5;

  always_ff @(posedge clk) begin
    s5    <= s4;
    root5 <= root4;
    zero5 <= zero4;
    sneg5 <= sneg4;
    prod5 <= PW'(stiffness) * PW'(smag4);
  end

  // --------------------------------------------------------------------------
  // stage 6: partial products of the numerators, blend by reciprocal of five
  // --------------------------------------------------------------------------
  logic [2:0][PW-1:0]         pl6, ph6;
  logic                       bsat6;
  logic [2*sfd_pkg::BX_W-1:0] bm6;
  logic [sfd_pkg::BX_W-1:0]   bx_c;
  logic [PW-1:0]              bsh_c;

  assign bsh_c = prod5 >> (2 * FRAC_BITS - 16);
  assign bx_c  = bsh_c[sfd_pkg::BX_W-1:0];

  always_ff @(posedge clk) begin
    s6    <= s5;
    root6 <= root5;
    zero6 <= zero5;
    sneg6 <= sneg5;
    for (int i = 0; i < 3; i++) begin
      pl6[i] <= PW'(prod5[32:0]) * PW'(s5.u[i]);
      ph6[i] <= PW'(prod5[PW-1:33]) * PW'(s5.u[i]);
    end
    bsat6 <= prod5 >= THR;
    bm6   <= (2 * sfd_pkg::BX_W)'(bx_c) * (2 * sfd_pkg::BX_W)'(sfd_pkg::BLEND_MUL);
  end

  // --------------------------------------------------------------------------
  // stage 7: numerators, divisor and result signs
  // --------------------------------------------------------------------------
  logic [2:0][sfd_pkg::NUM_W-1:0] num7;
  logic [DIV_W-1:0]               den7;
  dv_side_t                       dv_dl [QW+1];
  logic                           dv_v  [QW+1];
  logic [2*sfd_pkg::BX_W-1:0]     bq_c;

  assign bq_c = bm6 >> sfd_pkg::BLEND_SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v4 <= sq_v[RW];
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num7[i] <= sfd_pkg::NUM_W'(pl6[i]) + (sfd_pkg::NUM_W'(ph6[i]) << 33);
      dv_dl[0].neg[i] <= sneg6 ^ s6.dneg[i];
    end
    den7            <= DIV_W'(root6) << FRAC_BITS;
    dv_dl[0].frozen <= s6.frozen;
    dv_dl[0].zero   <= zero6;
    dv_dl[0].blend  <= bsat6 ? sfd_pkg::BLEND_ONE : sfd_pkg::BLD_W'(bq_c);
  end

  // --------------------------------------------------------------------------
  // divider lanes, one per axis
  // --------------------------------------------------------------------------
  logic [2:0][QW-1:0] quo;
  logic [2:0]         ovf;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    sfd_div #(.DIV_W(DIV_W)) u_div (
      .clk (clk),
      .num (num7[i]),
      .den (den7),
      .quo (quo[i]),
      .ovf (ovf[i])
    );
  end

  assign dv_v[0] = v7;

  for (genvar k = 0; k < QW; k++) begin : g_dv_dly
    always_ff @(posedge clk) begin
      dv_dl[k+1] <= dv_dl[k];
      if (rst) dv_v[k+1] <= 1'b0;
      else     dv_v[k+1] <= dv_v[k];
    end
  end

  // --------------------------------------------------------------------------
  // output stage: saturation, zero distance, done strobe
  // --------------------------------------------------------------------------
  dv_side_t so;
  assign so = dv_dl[QW];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_v[QW];
  end

  always_ff @(posedge clk) begin
    result.apply <= !so.frozen;
    if (so.zero) begin
      result.force_x      <= '0;
      result.force_y      <= '0;
      result.force_z      <= '0;
      result.stress_blend <= '0;
    end else begin
      result.force_x      <= sfd_pkg::sat_force(so.neg[0], quo[0], ovf[0]);
      result.force_y      <= sfd_pkg::sat_force(so.neg[1], quo[1], ovf[1]);
      result.force_z      <= sfd_pkg::sat_force(so.neg[2], quo[2], ovf[2]);
      result.stress_blend <= so.blend;
    end
  end

`ifndef SYNTHESIS
  // every accepted request produces exactly one result at the end of the pipeline
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("done missing after accepted request");

  // apply tracks the frozen flag of the matching request
  a_apply : assert property (@(posedge clk) disable iff (rst)
    done |-> result.apply == !$past(req.frozen, LAT))
    else $error("apply does not match request");

  // coincident ends give zero force and zero blend
  a_zero : assert property (@(posedge clk) disable iff (rst)
    (done && $past(req.end_a_x == req.end_b_x && req.end_a_y == req.end_b_y &&
                   req.end_a_z == req.end_b_z, LAT))
    |-> (result.force_x == 0 && result.force_y == 0 && result.force_z == 0 &&
         result.stress_blend == 0))
    else $error("nonzero force at zero distance");

  // blend never exceeds 1.0
  a_blend : assert property (@(posedge clk) disable iff (rst)
    done |-> result.stress_blend <= sfd_pkg::BLEND_ONE)
    else $error("stress blend above one");
`endif

endmodule
